// ===== src/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg: shared types, constants and helpers for sine_cosine_taylor
// Fixed-point constants in Q.31, reciprocal table and the rounded multiply.
// ----------------------------------------------------------------------------
package sct_pkg;

    // default formats of the ports
    localparam int ANGLE_FRAC_BITS_DEF  = 16;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    // internal fraction bits
    localparam int WFRAC = 31;

    // angle constants in Q.31 (2*pi and pi/2 are exact multiples of pi)
    localparam logic [33:0] TWO_PI_FX  = 34'h3243F6A88;
    localparam logic [33:0] PI_FX      = 34'h1921FB544;
    localparam logic [33:0] HALF_PI_FX = 34'h0C90FDAA2;
    localparam logic [33:0] ONE_FX     = 34'h080000000;

    // number of Horner terms
    localparam int NTERM = 5;

    // reciprocals in Q.31, in Horner order: 1/110, 1/72, 1/42, 1/20, 1/6
    localparam logic [31:0] RCP [0:NTERM-1] = '{
        32'd19522579, 32'd29826162, 32'd51130563, 32'd107374182, 32'd357913941
    };

    // folded angle and sign, handed from the front to the back
    typedef struct packed {
        logic        neg;
        logic [31:0] x;
    } sct_item_t;

    // rounded Q.31 product
    function automatic logic [33:0] qmul(input logic [33:0] a, input logic [33:0] b);
        logic [67:0] pr;
        pr = 68'(a) * 68'(b) + (68'd1 << (WFRAC - 1));
        return pr[WFRAC+33:WFRAC];
    endfunction

endpackage

// ===== src/sct_front.sv =====
// ----------------------------------------------------------------------------
// sct_front: angle reduction pipeline
// Offsets cosine by pi/2, reduces modulo 2*pi one quotient bit per stage,
// then folds into 0..pi/2 and tracks the sign.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int ANGLE_FRAC_BITS = sct_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_angle,
    input  logic                in_op,
    output logic                out_valid,
    input  logic                out_ready,
    output sct_pkg::sct_item_t  out_item
);

    localparam int SH    = sct_pkg::WFRAC - ANGLE_FRAC_BITS;
    localparam int AW    = 34 + SH;
    localparam int NSTEP = AW - 33;
    localparam int L     = NSTEP + 5;

    localparam logic [AW-1:0] TP_W   = AW'(sct_pkg::TWO_PI_FX);
    localparam logic [AW-1:0] HALF_W = AW'(sct_pkg::HALF_PI_FX);

    logic          en;
    logic [L-1:0]  vld_reg;

    logic [AW-1:0] a0_reg;
    logic          op0_reg;
    logic [AW-1:0] r_reg [0:NSTEP];
    logic          sg_reg [0:NSTEP];
    logic          op_reg [0:NSTEP];
    logic [33:0]   f1_reg;
    logic          f1_op_reg;
    logic [33:0]   f2_reg;
    logic          f2_neg_reg;
    logic          f2_op_reg;
    sct_pkg::sct_item_t f3_reg;

    logic [AW-1:0] a0_next;
    logic [33:0]   rr;

    // pipeline moves unless the last stage holds an item the queue refuses
    assign en        = !vld_reg[L-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[L-1];
    assign out_item  = f3_reg;

    // scaled angle, with the cosine offset
    always_comb
    begin
        a0_next = ({{(AW-32){in_angle[31]}}, in_angle} << SH) - (in_op ? HALF_W : '0);
    end

    assign rr = r_reg[NSTEP][33:0];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= a0_next;
            op0_reg <= in_op;

            // magnitude and sign of the dividend
            r_reg[0]  <= a0_reg[AW-1] ? (~a0_reg + 1'b1) : a0_reg;
            sg_reg[0] <= a0_reg[AW-1];
            op_reg[0] <= op0_reg;

            // restoring reduction, one multiple of 2*pi per stage
            for (int i = 1; i <= NSTEP; i++)
            begin
                if (r_reg[i-1] >= (TP_W << (NSTEP - i)))
                    r_reg[i] <= r_reg[i-1] - (TP_W << (NSTEP - i));
                else
                    r_reg[i] <= r_reg[i-1];
                sg_reg[i] <= sg_reg[i-1];
                op_reg[i] <= op_reg[i-1];
            end

            // negative remainder moves into 0..2*pi
            f1_reg    <= (sg_reg[NSTEP] && rr != '0) ? sct_pkg::TWO_PI_FX - rr : rr;
            f1_op_reg <= op_reg[NSTEP];

            // fold at pi; exactly pi counts as positive
            f2_neg_reg <= f1_reg > sct_pkg::PI_FX;
            f2_reg     <= (f1_reg >= sct_pkg::PI_FX) ? sct_pkg::TWO_PI_FX - f1_reg : f1_reg;
            f2_op_reg  <= f1_op_reg;

            // fold at pi/2, cosine flips the sign
            f3_reg.x   <= (f2_reg >= sct_pkg::HALF_PI_FX) ? 32'(sct_pkg::PI_FX - f2_reg)
                                                          : f2_reg[31:0];
            f3_reg.neg <= f2_neg_reg ^ f2_op_reg;
        end
    end

endmodule

// ===== src/sct_queue.sv =====
// ----------------------------------------------------------------------------
// sct_queue: small FIFO between front and back
// Four entries of folded angle and sign.
// ----------------------------------------------------------------------------
module sct_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sct_pkg::sct_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sct_pkg::sct_item_t  pop_item
);

    localparam int DEPTH = 4;
    localparam int AWD   = $clog2(DEPTH);

    sct_pkg::sct_item_t mem_reg [0:DEPTH-1];
    logic [AWD-1:0]     wp_reg;
    logic [AWD-1:0]     rp_reg;
    logic [AWD:0]       cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = cnt_reg != (AWD+1)'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_item;
    end

endmodule

// ===== src/sct_back.sv =====
// ----------------------------------------------------------------------------
// sct_back: Taylor polynomial pipeline
// Squares x, runs five Horner terms (two multiplies each), multiplies by x,
// rounds, saturates and applies the sign. The last stage is the output.
// ----------------------------------------------------------------------------
module sct_back #(
    parameter int RESULT_FRAC_BITS = sct_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sct_pkg::sct_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_value
);

    localparam int HS = 2;                          // first Horner stage
    localparam int NB = HS + 2 * sct_pkg::NTERM + 2; // total stages
    localparam int RSH = sct_pkg::WFRAC - RESULT_FRAC_BITS;
    localparam logic [33:0] RHALF = 34'(34'd1 << (RSH - 1));
    localparam logic [33:0] RMAX  = 34'(34'd1 << RESULT_FRAC_BITS);

    logic          en;
    logic [NB-1:0] vld_reg;
    logic [33:0]   x_reg   [0:NB-1];
    logic [33:0]   x2_reg  [0:NB-1];
    logic [33:0]   p_reg   [0:NB-1];
    logic          neg_reg [0:NB-1];
    logic [33:0]   mag_r;
    logic [33:0]   mag_c;
    logic [31:0]   value_reg;

    // 1 - t, clipped at zero
    function automatic logic [33:0] one_minus(input logic [33:0] t);
        return (t >= sct_pkg::ONE_FX) ? 34'd0 : sct_pkg::ONE_FX - t;
    endfunction

    assign en        = !vld_reg[NB-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NB-1];
    assign out_value = value_reg;

    // round to the result format and saturate
    always_comb
    begin
        mag_r = (p_reg[NB-2] + RHALF) >> RSH;
        mag_c = (mag_r > RMAX) ? RMAX : mag_r;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], in_valid};
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // entry stage
            x_reg[0]   <= {2'b00, in_item.x};
            neg_reg[0] <= in_item.neg;

            // carry operands along
            for (int s = 1; s < NB; s++)
            begin
                x_reg[s]   <= x_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int s = 2; s < NB; s++)
            begin
                x2_reg[s] <= x2_reg[s-1];
            end

            // square
            x2_reg[1] <= sct_pkg::qmul(x_reg[0], x_reg[0]);

            // first Horner term starts from one
            p_reg[HS] <= sct_pkg::qmul(x2_reg[HS-1], sct_pkg::ONE_FX);

            // Horner terms: multiply by x^2, then by the reciprocal
            for (int i = 1; i < 2 * sct_pkg::NTERM; i++)
            begin
                if (i[0] == 1'b0)
                    p_reg[HS+i] <= sct_pkg::qmul(x2_reg[HS+i-1], p_reg[HS+i-1]);
                else
                    p_reg[HS+i] <= one_minus(sct_pkg::qmul(p_reg[HS+i-1],
                                                           {2'b00, sct_pkg::RCP[i >> 1]}));
            end

            // times x
            p_reg[NB-2] <= sct_pkg::qmul(x_reg[NB-3], p_reg[NB-3]);

            // output with sign
            value_reg <= neg_reg[NB-2] ? 32'(~mag_c + 1'b1) : mag_c[31:0];
        end
    end

endmodule

// ===== src/sine_cosine_taylor.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor: fixed-point sine and cosine by Taylor polynomial
// Angle reduction front end, a short queue, and a polynomial back end.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per transfer, s_tdata = angle (Q15.16
//   by default), s_tuser = op (0 sine, 1 cosine).
//   Master channel m_*: one result per request, m_tdata = value (Q1.30 by
//   default, saturated to +/-1.0), in request order.
//   Throughput: one request per cycle while s_tready is high. The front
//   end reduces the angle one quotient bit per stage (32 - ANGLE_FRAC_BITS
//   stages, 16 by default, plus five setup and fold stages); the back end
//   has fourteen stages, at most one multiplier each, set by the five
//   two-multiply Horner terms. A request passes the front stages, the queue
//   and the back stages in order.
//   When m_tready is low the back end holds; the four-entry queue absorbs
//   the front end until it fills, then s_tready drops. Nothing is lost.
//   Reset (rst_n low) empties all stages and the queue; no warm-up.
// ----------------------------------------------------------------------------
module sine_cosine_taylor #(
    parameter int ANGLE_FRAC_BITS  = sct_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = sct_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    logic               f_valid;
    logic               f_ready;
    sct_pkg::sct_item_t f_item;
    logic               q_valid;
    logic               q_ready;
    sct_pkg::sct_item_t q_item;

    // angle reduction
    sct_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_angle (s_tdata),
        .in_op    (s_tuser),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_item (f_item)
    );

    // decoupling queue
    sct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_item (f_item),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (q_item)
    );

    // polynomial evaluation
    sct_back #(
        .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_value(m_tdata)
    );

endmodule

// ===== test/sine_cosine_taylor_chk.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor_chk: result predictor and scoreboard
// Watches both channels, computes each expected value from the request and
// compares it with the returned result in order.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_chk #(
    parameter int ANGLE_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          err_cnt,
    output int          pending
);

    localparam longint PI_Q31      = 64'sh1921FB544;
    localparam longint TWO_PI_Q31  = PI_Q31 * 2;
    localparam longint HALF_PI_Q31 = PI_Q31 / 2;
    localparam longint unsigned ONE_Q31 = 64'd1 << 31;

    logic [31:0] value_q[$];

    // rounded Q.31 product
    function automatic longint unsigned rmul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Horner stage: 1 - x2*p*rcp, floored at zero
    function automatic longint unsigned horner(longint unsigned x2, longint unsigned p,
                                               longint unsigned rcp);
        longint unsigned t;
        t = rmul(rmul(x2, p), rcp);
        return (t >= ONE_Q31) ? 64'd0 : ONE_Q31 - t;
    endfunction

    function automatic logic [31:0] predict_value(logic [31:0] angle, logic is_cos);
        longint a;
        bit neg;
        longint unsigned x, x2, p, mag;
        longint res;
        a = longint'($signed(angle)) * (longint'(1) << (31 - ANGLE_FRAC_BITS));
        if (is_cos)
            a -= HALF_PI_Q31;
        a = a % TWO_PI_Q31;
        if (a < 0)
            a += TWO_PI_Q31;
        neg = a > PI_Q31;
        if (a >= PI_Q31)
            a = TWO_PI_Q31 - a;
        if (a >= HALF_PI_Q31)
            a = PI_Q31 - a;
        if (is_cos)
            neg = !neg;
        x = longint'(a);
        x2 = (x * x + (64'd1 << 30)) >> 31;
        p = horner(x2, ONE_Q31, 64'd19522579);
        p = horner(x2, p, 64'd29826162);
        p = horner(x2, p, 64'd51130563);
        p = horner(x2, p, 64'd107374182);
        p = horner(x2, p, 64'd357913941);
        mag = rmul(x, p);
        mag = (mag + (64'd1 << (31 - RESULT_FRAC_BITS - 1))) >> (31 - RESULT_FRAC_BITS);
        if (mag > (64'd1 << RESULT_FRAC_BITS))
            mag = 64'd1 << RESULT_FRAC_BITS;
        res = longint'(mag);
        if (neg)
            res = -res;
        return res[31:0];
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // request capture and result compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                value_q.push_back(predict_value(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (value_q.size() == 0)
                    report("unexpected result", m_tdata, 32'h0);
                else if (m_tdata !== value_q[0])
                begin
                    report("value", m_tdata, value_q[0]);
                    void'(value_q.pop_front());
                end
                else
                    void'(value_q.pop_front());
            end
        end
        pending = value_q.size();
    end

endmodule

// ===== test/sine_cosine_taylor_tb.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor_tb: stream test of the sine/cosine unit
// Directed corner angles then random angles, bursty requests and a
// patterned result stall; the checker scores every result.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_tb;

    localparam int N_RANDOM  = 1950;
    localparam int WDOG_MAX  = 2000;
    localparam int DRAIN_CYC = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] angle
    logic        s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] value
    int          err_cnt;
    int          pending;
    int          idle_cyc;

    logic [31:0] angle_list[$];
    logic        op_list[$];

    sine_cosine_taylor dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sine_cosine_taylor_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .err_cnt(err_cnt), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stall pattern: mode from bits [7:6] of a free-running cycle counter
    int rcv_cyc = 0;
    always @(posedge clk)
    begin
        rcv_cyc <= rcv_cyc + 1;
        case ((rcv_cyc >> 6) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ((rcv_cyc % 7) < 2);
        endcase
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(logic [31:0] angle, logic op);
        angle_list.push_back(angle);
        op_list.push_back(op);
    endtask

    initial
    begin
        int burst;
        int gap;
        int k;
        logic [31:0] base;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;

        // directed: extremes, zero, pi multiples (sign at exactly pi), both ops
        for (int op = 0; op < 2; op++)
        begin
            add_req(32'h0000_0000, op[0]);
            add_req(32'h7FFF_FFFF, op[0]);
            add_req(32'h8000_0000, op[0]);
            add_req(32'hFFFF_FFFF, op[0]);
            add_req(32'h0003_243F, op[0]);   // about pi
            add_req(32'h0003_2440, op[0]);
            add_req(32'h0001_921F, op[0]);   // about pi/2, sine magnitude near one
            add_req(32'h0001_9220, op[0]);
            add_req(32'hFFFC_DBC1, op[0]);   // about -pi
            add_req(32'h0006_487F, op[0]);   // about 2*pi
            add_req(32'h0004_B65F, op[0]);   // about 3*pi/2
        end
        // random: mostly near multiples of pi/2, rest full range
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                base = $urandom();
            else
            begin
                k = $urandom_range(0, 40) - 20;
                base = 32'(k * 102944) + 32'($urandom_range(0, 16) - 8);
            end
            add_req(base, 1'($urandom_range(0, 1)));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // bursty sender
        while (angle_list.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && angle_list.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= angle_list[0];
                s_tuser  <= op_list[0];
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                void'(angle_list.pop_front());
                void'(op_list.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
